@@ rtl/elx_pkg.sv @@
// Shared types, constants and codes of the expression lexer.
`default_nettype none
package elx_pkg;

    localparam int     MAX_IDENT_LEN = 1024;
    localparam longint TEXT_LENGTH   = 65536;
    localparam int     CNT_W         = $clog2(TEXT_LENGTH + 1);

    localparam int POS_W = 16;
    localparam int LEN_W = 11;
    localparam int VAL_W = 31;

    localparam logic [VAL_W-1:0] NUM_MAX = {VAL_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] KW_LEN  = LEN_W'(6);

    // Token kinds.
    localparam logic [2:0] K_SYM   = 3'd0;
    localparam logic [2:0] K_NUM   = 3'd1;
    localparam logic [2:0] K_IDENT = 3'd2;
    localparam logic [2:0] K_END   = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    // Symbol codes.
    localparam logic [3:0] SYM_PLUS   = 4'd0;
    localparam logic [3:0] SYM_MINUS  = 4'd1;
    localparam logic [3:0] SYM_STAR   = 4'd2;
    localparam logic [3:0] SYM_SLASH  = 4'd3;
    localparam logic [3:0] SYM_LPAREN = 4'd4;
    localparam logic [3:0] SYM_RPAREN = 4'd5;
    localparam logic [3:0] SYM_LT     = 4'd6;
    localparam logic [3:0] SYM_GT     = 4'd7;
    localparam logic [3:0] SYM_ASSIGN = 4'd8;
    localparam logic [3:0] SYM_SEMI   = 4'd9;
    localparam logic [3:0] SYM_EQ     = 4'd10;
    localparam logic [3:0] SYM_NE     = 4'd11;
    localparam logic [3:0] SYM_LE     = 4'd12;
    localparam logic [3:0] SYM_GE     = 4'd13;
    localparam logic [3:0] SYM_RETURN = 4'd14;

    // Character classes produced by the front end.
    typedef enum logic [3:0] {
        CL_SPACE   = 4'd0,
        CL_SINGLE  = 4'd1,
        CL_LT      = 4'd2,
        CL_GT      = 4'd3,
        CL_EQ      = 4'd4,
        CL_BANG    = 4'd5,
        CL_DIGIT   = 4'd6,
        CL_ALPHA   = 4'd7,
        CL_ILLEGAL = 4'd8
    } t_cls;

    typedef struct packed {
        logic       cmd;
        logic [7:0] text_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]       token_kind;
        logic [3:0]       symbol_code;
        logic [VAL_W-1:0] number_value;
        logic [POS_W-1:0] start_offset;
        logic [LEN_W-1:0] token_length;
        logic             value_saturated;
        logic             last_of_run;
    } t_out;

    // One classified byte as it travels from the front end to the scanner.
    typedef struct packed {
        logic             eot;
        t_cls             cls;
        logic [3:0]       sym;
        logic [3:0]       digit;
        logic [5:0]       kwm;
        logic [POS_W-1:0] pos;
    } t_item;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage
`default_nettype wire

@@ rtl/elx_front.sv @@
// Front end: accepts text bytes, tracks position and classifies each byte.
`default_nettype none
module elx_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  elx_pkg::t_in       i_in,
    output logic               o_item_valid,
    input  wire logic          i_item_ready,
    output elx_pkg::t_item     o_item
);

    logic [elx_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_valid, n_valid;
    elx_pkg::t_item            r_item, n_item;
    logic                      take;
    logic                      at_limit;
    logic                      eot;

    function automatic elx_pkg::t_item classify(input logic [7:0] c);
        elx_pkg::t_item it;
        it       = '0;
        it.cls   = elx_pkg::CL_ILLEGAL;
        it.digit = c[3:0];
        it.kwm   = {c == 8'h6E, c == 8'h72, c == 8'h75, c == 8'h74, c == 8'h65, c == 8'h72};
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            it.cls = elx_pkg::CL_SPACE;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            it.cls = elx_pkg::CL_DIGIT;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                     || c == 8'h5F) begin
            it.cls = elx_pkg::CL_ALPHA;
        end else begin
            unique case (c)
                8'h2B: begin it.cls = elx_pkg::CL_SINGLE; it.sym = elx_pkg::SYM_PLUS; end
                8'h2D: begin it.cls = elx_pkg::CL_SINGLE; it.sym = elx_pkg::SYM_MINUS; end
                8'h2A: begin it.cls = elx_pkg::CL_SINGLE; it.sym = elx_pkg::SYM_STAR; end
                8'h2F: begin it.cls = elx_pkg::CL_SINGLE; it.sym = elx_pkg::SYM_SLASH; end
                8'h28: begin it.cls = elx_pkg::CL_SINGLE; it.sym = elx_pkg::SYM_LPAREN; end
                8'h29: begin it.cls = elx_pkg::CL_SINGLE; it.sym = elx_pkg::SYM_RPAREN; end
                8'h3B: begin it.cls = elx_pkg::CL_SINGLE; it.sym = elx_pkg::SYM_SEMI; end
                8'h3C: it.cls = elx_pkg::CL_LT;
                8'h3E: it.cls = elx_pkg::CL_GT;
                8'h3D: it.cls = elx_pkg::CL_EQ;
                8'h21: it.cls = elx_pkg::CL_BANG;
                default: it.cls = elx_pkg::CL_ILLEGAL;
            endcase
        end
        return it;
    endfunction

    assign o_in_ready   = !r_valid || i_item_ready;
    assign take         = i_in_valid && o_in_ready;
    assign at_limit     = r_cnt >= elx_pkg::CNT_W'(elx_pkg::TEXT_LENGTH);
    assign eot          = i_in.cmd || (i_in.text_byte == 8'h00) || at_limit;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_item  = r_item;
        if (r_valid && i_item_ready) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid     = 1'b1;
            n_item      = classify(i_in.text_byte);
            n_item.eot  = eot;
            n_item.pos  = elx_pkg::POS_W'(r_cnt);
            // Only text bytes advance the position; it stops at the text limit.
            if (!eot) begin
                n_cnt = r_cnt + elx_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule
`default_nettype wire

@@ rtl/elx_queue.sv @@
// Short queue of classified bytes between the front end and the scanner.
`default_nettype none
module elx_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  elx_pkg::t_item     i_push_item,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output elx_pkg::t_item     o_pop_item
);

    elx_pkg::t_item             r_mem [elx_pkg::QDEPTH];
    logic [elx_pkg::QPTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [elx_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic                       push, pop;

    assign o_push_ready = r_cnt != elx_pkg::QCNT_W'(elx_pkg::QDEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = push ? r_wr + elx_pkg::QPTR_W'(1) : r_wr;
        n_rd  = pop  ? r_rd + elx_pkg::QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + elx_pkg::QCNT_W'(push) - elx_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/elx_back.sv @@
// Scanner: builds tokens from classified bytes and buffers them for output.
`default_nettype none
module elx_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_item_valid,
    output logic               o_item_ready,
    input  elx_pkg::t_item     i_item,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output elx_pkg::t_out      o_out
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NUM   = 8'b0000_0010,
        S_IDENT = 8'b0000_0100,
        S_LT    = 8'b0000_1000,
        S_GT    = 8'b0001_0000,
        S_EQ    = 8'b0010_0000,
        S_BANG  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_mode;

    localparam int OB_DEPTH = 4;
    localparam int OB_PTR_W = $clog2(OB_DEPTH);
    localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);
    localparam int PROD_W   = elx_pkg::VAL_W + 4;

    t_mode                      r_mode, n_mode;
    logic [elx_pkg::POS_W-1:0]  r_start, n_start;
    logic [elx_pkg::LEN_W-1:0]  r_len, n_len;
    logic [elx_pkg::VAL_W-1:0]  r_acc, n_acc;
    logic                       r_sat, n_sat;
    logic                       r_kw, n_kw;

    elx_pkg::t_out              r_obuf [OB_DEPTH];
    logic [OB_PTR_W-1:0]        r_wr, r_rd;
    logic [OB_CNT_W-1:0]        r_cnt;

    logic                       take, pop;
    logic                       fresh;
    logic [1:0]                 ntok;
    elx_pkg::t_out              tok0, tok1;
    logic                       is_eq, is_digit, is_ident;
    logic [PROD_W-1:0]          prod;
    logic [2:0]                 kw_idx;

    function automatic elx_pkg::t_out mk(input logic [2:0] kind, input logic [3:0] sym,
                                         input logic [elx_pkg::VAL_W-1:0] val,
                                         input logic [elx_pkg::POS_W-1:0] start,
                                         input logic [elx_pkg::LEN_W-1:0] len,
                                         input logic sat);
        elx_pkg::t_out t;
        t.token_kind      = kind;
        t.symbol_code     = sym;
        t.number_value    = val;
        t.start_offset    = start;
        t.token_length    = len;
        t.value_saturated = sat;
        t.last_of_run     = 1'b0;
        return t;
    endfunction

    // Room for two tokens is required before an item is taken.
    assign o_item_ready = r_cnt <= OB_CNT_W'(OB_DEPTH - 2);
    assign take         = i_item_valid && o_item_ready;
    assign o_out_valid  = r_cnt != '0;
    assign o_out        = r_obuf[r_rd];
    assign pop          = o_out_valid && i_out_ready;

    assign is_eq    = !i_item.eot && i_item.cls == elx_pkg::CL_EQ;
    assign is_digit = !i_item.eot && i_item.cls == elx_pkg::CL_DIGIT;
    assign is_ident = !i_item.eot && (i_item.cls == elx_pkg::CL_DIGIT
                                      || i_item.cls == elx_pkg::CL_ALPHA);
    assign prod     = (PROD_W'(r_acc) << 3) + (PROD_W'(r_acc) << 1) + PROD_W'(i_item.digit);
    assign kw_idx   = r_len[2:0];

    // Place the tokens of one item in order, counting them as they appear.
    always_comb begin
        elx_pkg::t_out t;
        logic          have;
        n_mode  = r_mode;
        n_start = r_start;
        n_len   = r_len;
        n_acc   = r_acc;
        n_sat   = r_sat;
        n_kw    = r_kw;
        fresh   = 1'b1;
        have    = 1'b0;
        t       = '0;
        ntok    = 2'd0;
        tok0    = '0;
        tok1    = '0;

        unique case (r_mode)
            S_LT, S_GT, S_EQ: begin
                if (is_eq) begin
                    have  = 1'b1;
                    fresh = 1'b0;
                    t     = mk(elx_pkg::K_SYM,
                               (r_mode == S_LT) ? elx_pkg::SYM_LE :
                               (r_mode == S_GT) ? elx_pkg::SYM_GE : elx_pkg::SYM_EQ,
                               '0, r_start, elx_pkg::LEN_W'(2), 1'b0);
                end else begin
                    have = 1'b1;
                    t    = mk(elx_pkg::K_SYM,
                              (r_mode == S_LT) ? elx_pkg::SYM_LT :
                              (r_mode == S_GT) ? elx_pkg::SYM_GT : elx_pkg::SYM_ASSIGN,
                              '0, r_start, elx_pkg::LEN_W'(1), 1'b0);
                end
                n_mode = S_IDLE;
            end
            S_BANG: begin
                have  = 1'b1;
                fresh = 1'b0;
                if (is_eq) begin
                    t      = mk(elx_pkg::K_SYM, elx_pkg::SYM_NE, '0, r_start,
                                elx_pkg::LEN_W'(2), 1'b0);
                    n_mode = S_IDLE;
                end else begin
                    t      = mk(elx_pkg::K_ERR, '0, '0, r_start, '0, 1'b0);
                    n_mode = S_DONE;
                end
            end
            S_NUM: begin
                if (is_digit) begin
                    fresh = 1'b0;
                    if (prod > PROD_W'(elx_pkg::NUM_MAX)) begin
                        n_acc = elx_pkg::NUM_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = elx_pkg::VAL_W'(prod);
                    end
                    if (r_len != elx_pkg::LEN_MAX) begin
                        n_len = r_len + elx_pkg::LEN_W'(1);
                    end
                end else begin
                    have   = 1'b1;
                    t      = mk(elx_pkg::K_NUM, '0, r_acc, r_start, r_len, r_sat);
                    n_mode = S_IDLE;
                end
            end
            S_IDENT: begin
                if (is_ident && r_len < elx_pkg::LEN_W'(elx_pkg::MAX_IDENT_LEN)) begin
                    fresh = 1'b0;
                    n_kw  = r_kw && (r_len < elx_pkg::KW_LEN) && i_item.kwm[kw_idx];
                    n_len = r_len + elx_pkg::LEN_W'(1);
                end else begin
                    have = 1'b1;
                    // A full identifier is split even if it spells the keyword.
                    if (!is_ident && r_kw && r_len == elx_pkg::KW_LEN) begin
                        t = mk(elx_pkg::K_SYM, elx_pkg::SYM_RETURN, '0, r_start,
                               elx_pkg::KW_LEN, 1'b0);
                    end else begin
                        t = mk(elx_pkg::K_IDENT, '0, '0, r_start, r_len, 1'b0);
                    end
                    n_mode = S_IDLE;
                end
            end
            S_DONE: begin
                fresh = 1'b0;
            end
            default: begin
                n_mode = S_IDLE;
            end
        endcase

        if (have) begin
            tok0 = t;
            ntok = 2'd1;
        end

        if (fresh) begin
            have = 1'b0;
            t    = '0;
            if (i_item.eot) begin
                have   = 1'b1;
                t      = mk(elx_pkg::K_END, '0, '0, i_item.pos, '0, 1'b0);
                n_mode = S_DONE;
            end else begin
                unique case (i_item.cls)
                    elx_pkg::CL_SPACE: ;
                    elx_pkg::CL_SINGLE: begin
                        have = 1'b1;
                        t    = mk(elx_pkg::K_SYM, i_item.sym, '0, i_item.pos,
                                  elx_pkg::LEN_W'(1), 1'b0);
                    end
                    elx_pkg::CL_LT: begin
                        n_mode  = S_LT;
                        n_start = i_item.pos;
                    end
                    elx_pkg::CL_GT: begin
                        n_mode  = S_GT;
                        n_start = i_item.pos;
                    end
                    elx_pkg::CL_EQ: begin
                        n_mode  = S_EQ;
                        n_start = i_item.pos;
                    end
                    elx_pkg::CL_BANG: begin
                        n_mode  = S_BANG;
                        n_start = i_item.pos;
                    end
                    elx_pkg::CL_DIGIT: begin
                        n_mode  = S_NUM;
                        n_start = i_item.pos;
                        n_len   = elx_pkg::LEN_W'(1);
                        n_acc   = elx_pkg::VAL_W'(i_item.digit);
                        n_sat   = 1'b0;
                    end
                    elx_pkg::CL_ALPHA: begin
                        n_mode  = S_IDENT;
                        n_start = i_item.pos;
                        n_len   = elx_pkg::LEN_W'(1);
                        n_kw    = i_item.kwm[0];
                    end
                    default: begin
                        have   = 1'b1;
                        t      = mk(elx_pkg::K_ERR, '0, '0, i_item.pos, '0, 1'b0);
                        n_mode = S_DONE;
                    end
                endcase
            end
            if (have) begin
                if (ntok == 2'd1) begin
                    tok1 = t;
                    ntok = 2'd2;
                end else begin
                    tok0 = t;
                    ntok = 2'd1;
                end
            end
        end

        if (ntok == 2'd2) begin
            tok1.last_of_run = 1'b1;
        end else begin
            tok0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_kw    <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (take) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_len   <= n_len;
                r_acc   <= n_acc;
                r_sat   <= n_sat;
                r_kw    <= n_kw;
                r_wr    <= r_wr + OB_PTR_W'(ntok);
            end
            if (pop) begin
                r_rd <= r_rd + OB_PTR_W'(1);
            end
            r_cnt <= r_cnt + (take ? OB_CNT_W'(ntok) : '0) - OB_CNT_W'(pop);
        end
        if (take && ntok != 2'd0) begin
            r_obuf[r_wr] <= tok0;
        end
        if (take && ntok == 2'd2) begin
            r_obuf[r_wr + OB_PTR_W'(1)] <= tok1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/expression_lexer.sv @@
// Top level of the expression lexer: front end, queue and scanner.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_ready   i_in  (cmd, text_byte)
//   output   out        o_out_valid / i_out_ready o_out (one token)
//
// One byte is accepted per cycle while the queue has room. A byte passes through the
// front register and the queue to the scanner; its tokens reach o_out through the
// output buffer, which drains one token per cycle while i_out_ready is high. Reset
// is synchronous and clears position, scan state and buffers.
// Each side stalls on its own: the four-entry queue and the token buffer absorb
// stalls, and input ready depends on queue occupancy and the front register only.
`default_nettype none
module expression_lexer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  elx_pkg::t_in       i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output elx_pkg::t_out      o_out
);

    logic           f_valid, f_ready;
    elx_pkg::t_item f_item;
    logic           q_valid, q_ready;
    elx_pkg::t_item q_item;

    elx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    elx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    elx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire
